// File: rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants for the discrete distribution sampler
// Beat payload structs, controller command/status bundles, operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH   = 64;
  localparam int IDX_BITS      = 6;
  localparam int CNT_BITS      = 7;
  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS;
  localparam int PROD_BITS     = SUM_BITS + FRACTION_BITS;

  localparam logic [CNT_BITS-1:0] TABLE_SIZE_RESET = CNT_BITS'(TABLE_DEPTH);

  // Operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_PREP   = 2'd2;
  localparam logic [1:0] OP_SAMPLE = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_BITS-1:0]      entry_index;
    logic [WEIGHT_BITS-1:0]   weight_value;
    logic [FRACTION_BITS-1:0] random_fraction;
    logic [CNT_BITS-1:0]      sample_limit;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] sampled_index;
    logic                found;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                load_item;
    logic                w_we;
    logic                w_one;
    logic [IDX_BITS-1:0] w_addr;
    logic [IDX_BITS-1:0] w_raddr;
    logic                acc_clr;
    logic                sum_we;
    logic [IDX_BITS-1:0] sum_waddr;
    logic [IDX_BITS-1:0] s_raddr;
    logic                prod_load;
    logic                res_load;
    logic                res_found;
    logic [IDX_BITS-1:0] res_idx;
    logic                out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic out_free;
  } status_t;

  // Saturate a count at the table depth
  function automatic logic [CNT_BITS-1:0] clamp_depth(input logic [CNT_BITS-1:0] n);
    clamp_depth = (n > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dds_ctrl.sv
// ----------------------------------------------------------------------------
// dds_ctrl: operation sequencer
// Decodes each accepted beat and steps the table walks for fill, prepare
// and sample, issuing memory and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_ctrl import dds_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  input  logic [CNT_BITS-1:0] table_size,
  input  status_t             status,
  output cmd_t                cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FILL     = 3'd1;
  localparam logic [2:0] S_PREP     = 3'd2;
  localparam logic [2:0] S_PREP_END = 3'd3;
  localparam logic [2:0] S_TOT      = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]          state, state_next;
  logic [IDX_BITS-1:0] cnt, cnt_next;
  logic [IDX_BITS-1:0] last_idx, last_idx_next;
  logic                pend;
  logic [IDX_BITS-1:0] pidx;

  logic [CNT_BITS-1:0] used;
  logic [CNT_BITS-1:0] lim_in;
  logic                accept;
  logic                is_last;

  assign used     = clamp_depth(table_size);
  assign lim_in   = clamp_depth(in_data.sample_limit);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_last  = (cnt == last_idx);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    last_idx_next = last_idx;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          unique case (in_data.operation)
            OP_WRITE: begin
              cmd.w_we   = 1'b1;
              cmd.w_addr = in_data.entry_index;
            end
            OP_FILL: begin
              if (used != '0) begin
                cnt_next      = '0;
                last_idx_next = IDX_BITS'(used - CNT_BITS'(1));
                state_next    = S_FILL;
              end
            end
            OP_PREP: begin
              if (used != '0) begin
                cmd.acc_clr   = 1'b1;
                cnt_next      = '0;
                last_idx_next = IDX_BITS'(used - CNT_BITS'(1));
                state_next    = S_PREP;
              end
            end
            OP_SAMPLE: begin
              if (lim_in == '0) begin
                cmd.res_load  = 1'b1;
                cmd.res_found = 1'b0;
                cmd.res_idx   = '0;
                state_next    = S_DONE;
              end else begin
                // fetch the total at limit-1
                cmd.s_raddr   = IDX_BITS'(lim_in - CNT_BITS'(1));
                last_idx_next = IDX_BITS'(lim_in - CNT_BITS'(1));
                state_next    = S_TOT;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.w_we   = 1'b1;
        cmd.w_one  = 1'b1;
        cmd.w_addr = cnt;
        if (is_last) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + IDX_BITS'(1);
        end
      end
      S_PREP: begin
        // read entry cnt, write the sum of the entry read last cycle
        cmd.w_raddr   = cnt;
        cmd.sum_we    = pend;
        cmd.sum_waddr = pidx;
        if (is_last) begin
          state_next = S_PREP_END;
        end else begin
          cnt_next = cnt + IDX_BITS'(1);
        end
      end
      S_PREP_END: begin
        cmd.sum_we    = pend;
        cmd.sum_waddr = pidx;
        state_next    = S_IDLE;
      end
      S_TOT: begin
        cmd.prod_load = 1'b1;
        cmd.s_raddr   = '0;
        cnt_next      = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.s_raddr = cnt + IDX_BITS'(1);
        if (status.hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = 1'b1;
          cmd.res_idx   = cnt;
          state_next    = S_DONE;
        end else if (is_last) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = 1'b0;
          cmd.res_idx   = '0;
          state_next    = S_DONE;
        end else begin
          cnt_next = cnt + IDX_BITS'(1);
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_PREP);
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    last_idx <= last_idx_next;
    pidx     <= cnt;
  end

endmodule

`default_nettype wire

// File: rtl/dds_dp.sv
// ----------------------------------------------------------------------------
// dds_dp: sampler datapath
// Weight and running-sum memories with per-entry valid bits, the running
// accumulator, the fraction-times-total multiplier, comparator and the
// result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_dp import dds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [WEIGHT_BITS-1:0]   wmem [TABLE_DEPTH];
  logic [SUM_BITS-1:0]      smem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   wvalid;
  logic [TABLE_DEPTH-1:0]   svalid;

  logic [WEIGHT_BITS-1:0]   wrd;
  logic                     wrd_valid;
  logic [SUM_BITS-1:0]      srd;
  logic                     srd_valid;

  logic [WEIGHT_BITS-1:0]   w_wdata;
  logic [WEIGHT_BITS-1:0]   w_eff;
  logic [SUM_BITS-1:0]      s_eff;
  logic [SUM_BITS-1:0]      acc;
  logic [SUM_BITS-1:0]      sum_wdata;
  logic [FRACTION_BITS-1:0] frac;
  logic [PROD_BITS-1:0]     prod;
  logic [PROD_BITS-1:0]     prod_calc;
  logic [PROD_BITS-1:0]     sum_scaled;
  logic [IDX_BITS-1:0]      res_idx;
  logic                     res_found;

  assign w_wdata   = cmd.w_one ? WEIGHT_BITS'(1) : in_data.weight_value;
  // entries never written read as zero
  assign w_eff     = wrd_valid ? wrd : '0;
  assign s_eff     = srd_valid ? srd : '0;
  assign sum_wdata = acc + SUM_BITS'(w_eff);

  // Weight memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.w_we) begin
      wmem[cmd.w_addr] <= w_wdata;
    end
    wrd <= wmem[cmd.w_raddr];
  end

  // Running-sum memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.sum_we) begin
      smem[cmd.sum_waddr] <= sum_wdata;
    end
    srd <= smem[cmd.s_raddr];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid    <= '0;
      svalid    <= '0;
      wrd_valid <= 1'b0;
      srd_valid <= 1'b0;
    end else begin
      if (cmd.w_we) begin
        wvalid[cmd.w_addr] <= 1'b1;
      end
      if (cmd.sum_we) begin
        svalid[cmd.sum_waddr] <= 1'b1;
      end
      wrd_valid <= wvalid[cmd.w_raddr];
      srd_valid <= svalid[cmd.s_raddr];
    end
  end

  // Accumulator and latched fraction
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.sum_we) begin
      acc <= sum_wdata;
    end
    if (cmd.load_item) begin
      frac <= in_data.random_fraction;
    end
  end

  // Threshold: fraction times total, compared against sum scaled by 2^F
  assign prod_calc  = {{SUM_BITS{1'b0}}, frac} * {{FRACTION_BITS{1'b0}}, s_eff};
  assign sum_scaled = {s_eff, {FRACTION_BITS{1'b0}}};
  assign status.hit = (prod < sum_scaled);

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      prod <= prod_calc;
    end
    if (cmd.res_load) begin
      res_idx   <= cmd.res_idx;
      res_found <= cmd.res_found;
    end
  end

  // Output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.sampled_index <= res_idx;
      out_data.found         <= res_found;
    end
  end

endmodule

`default_nettype wire

// File: rtl/discrete_distribution_sampler_core.sv
// ----------------------------------------------------------------------------
// discrete_distribution_sampler_core: inverse-transform discrete sampler
// Holds a weight table and its running sums; samples the first index whose
// running sum exceeds fraction * total.
//
//   channel  | signals                       | moves
//   ---------+-------------------------------+-------------------------------
//   cfg      | cfg_valid, cfg_ready, cfg_data| table_size write, always ready
//   in       | in_valid, in_ready, in_data   | one operation per beat
//   out      | out_valid, out_ready, out_data| one result per sample beat
//
// A new beat is taken only in idle. Write stores its entry; fill and prepare
// walk n = table_size entries capped at the depth. Sample reads the total, then
// compares up to the hit or the limit, one running-sum entry read a cycle.
// Reset clears both tables at once through per-entry valid bits.
// A finished result waits in the output register while a new beat is taken;
// only a second sample result stalls until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_distribution_sampler_core import dds_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CNT_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  logic [CNT_BITS-1:0] table_size;
  cmd_t                cmd;
  status_t             status;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  dds_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .table_size (table_size),
    .status     (status),
    .cmd        (cmd)
  );

  dds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
